// File: sv/ilid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and constants for the indexed list core
// Store geometry, field widths, operation and error codes, FSM states.
// ----------------------------------------------------------------------------
package ilid_pkg;

  // Store geometry
  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = CNT_W + 1;

  // Interface field widths
  localparam int KIND_W  = 3;
  localparam int INDEX_W = 10;
  localparam int WORD_W  = 32;
  localparam int ERR_W   = 2;
  localparam int ICAP_W  = 11;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_DELETE = 3'd2,
    KIND_EDIT   = 3'd3,
    KIND_READ   = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_t;

  // Result error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_INDEX = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PUT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: sv/ilid_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilid_if: channel interfaces of the indexed list core
// Command, response and configuration channels, each valid/ready.
// ----------------------------------------------------------------------------

// Command channel: one list operation per transfer
interface ilid_cmd_if;
  import ilid_pkg::*;
  logic                      valid;
  logic                      ready;
  logic        [KIND_W-1:0]  kind;
  logic        [INDEX_W-1:0] index;
  logic signed [WORD_W-1:0]  value;

  modport source (output valid, kind, index, value, input ready);
  modport sink   (input valid, kind, index, value, output ready);
endinterface

// Response channel: one result per command
interface ilid_rsp_if;
  import ilid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic        [ERR_W-1:0]  error;
  logic        [CNT_W-1:0]  count;
  logic        [CAP_W-1:0]  capacity;

  modport source (output valid, read_value, error, count, capacity, input ready);
  modport sink   (input valid, read_value, error, count, capacity, output ready);
endinterface

// Configuration channel: initial capacity register write
interface ilid_cfg_if;
  import ilid_pkg::*;
  logic              valid;
  logic              ready;
  logic [ICAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: sv/indexed_list_insert_delete_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core: ordered list of signed words in one RAM
// Append, insert, delete, edit, read and clear, with logical capacity tracking.
// ----------------------------------------------------------------------------
// Usage:
//   cmd : one operation per transfer (kind, index, value). Taken only while
//         the sequencer is idle; one operation is in flight at a time.
//   rsp : exactly one result per command (read_value, error, count, capacity),
//         held in an output register until the transfer completes.
//   cfg : writes the initial capacity; always ready, write only while idle.
// Insert and delete move every later entry through the single-port read /
// single-port write RAM, one entry per cycle, so the worst case moves
// DEPTH - 1 entries per item.
// Reset clears the count, loads capacity 1 and the register value 1; RAM
// contents are not cleared and need no clearing pass.
// A stalled rsp holds its result; the next command can be taken meanwhile,
// and its result waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_core
  import ilid_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  ilid_cfg_if.sink   cfg,
  ilid_cmd_if.sink   cmd,
  ilid_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_ONES,
    RD_MEM
  } rsel_t;

  // Element store
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;

  // Control state
  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CAP_W-1:0]  cap, cap_next;
  logic [ICAP_W-1:0] init_cap;
  logic              pend, pend_next;
  logic              out_valid;

  // Per-item working registers
  logic [ADDR_W-1:0]     pend_addr, pend_addr_next;
  logic [ADDR_W-1:0]     rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]      rd_left, rd_left_next;
  logic                  op_ins, op_ins_next;
  err_t                  op_err, op_err_next;
  rsel_t                 rsel, rsel_next;
  logic [ADDR_W-1:0]     put_addr, put_addr_next;
  logic [DATA_WIDTH-1:0] put_word, put_word_next;

  // Output register
  logic [WORD_W-1:0] out_read;
  err_t              out_err;
  logic [CNT_W-1:0]  out_count;
  logic [CAP_W-1:0]  out_cap;
  logic              out_load;
  logic [WORD_W-1:0] read_mux;

  logic              accept;
  logic              idx_good;
  logic              full;
  logic              at_cap;
  logic [CNT_W-1:0]  count_dec;
  logic [CAP_W-1:0]  start_cap;

  // Handshakes
  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && (state == ST_IDLE);

  // Checks against the current list
  assign idx_good  = {1'b0, cmd.index} < count;
  assign full      = count == CNT_W'(DEPTH);
  assign at_cap    = {1'b0, count} == cap;
  assign count_dec = count - CNT_W'(1);

  // Initial capacity kept within 1..DEPTH
  always_comb begin
    if (init_cap == '0) begin
      start_cap = CAP_W'(1);
    end else if ({1'b0, init_cap} > CAP_W'(DEPTH)) begin
      start_cap = CAP_W'(DEPTH);
    end else begin
      start_cap = {1'b0, init_cap};
    end
  end

  // Next state, list bookkeeping and RAM control
  always_comb begin
    state_next     = state;
    count_next     = count;
    cap_next       = cap;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;
    rd_ptr_next    = rd_ptr;
    rd_left_next   = rd_left;
    op_ins_next    = op_ins;
    op_err_next    = op_err;
    rsel_next      = rsel;
    put_addr_next  = put_addr;
    put_word_next  = put_word;
    mem_we         = 1'b0;
    mem_waddr      = pend_addr;
    mem_wdata      = rd_data;
    mem_re         = 1'b0;
    mem_raddr      = rd_ptr;
    out_load       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op_err_next = ERR_OK;
          rsel_next   = RD_ZERO;
          state_next  = ST_DONE;
          unique case (cmd.kind)
            KIND_APPEND: begin
              if (full) begin
                op_err_next = ERR_FULL;
              end else begin
                if (at_cap) cap_next = cap << 1;
                mem_we     = 1'b1;
                mem_waddr  = count[ADDR_W-1:0];
                mem_wdata  = cmd.value[DATA_WIDTH-1:0];
                count_next = count + CNT_W'(1);
              end
            end
            KIND_INSERT: begin
              if (!idx_good) begin
                op_err_next = ERR_INDEX;
              end else if (full) begin
                op_err_next = ERR_FULL;
              end else begin
                if (at_cap) cap_next = cap << 1;
                count_next    = count + CNT_W'(1);
                rd_ptr_next   = count_dec[ADDR_W-1:0];
                rd_left_next  = count - {1'b0, cmd.index};
                op_ins_next   = 1'b1;
                put_addr_next = cmd.index;
                put_word_next = cmd.value[DATA_WIDTH-1:0];
                state_next    = ST_SHIFT;
              end
            end
            KIND_DELETE: begin
              if (!idx_good) begin
                op_err_next = ERR_INDEX;
              end else begin
                count_next   = count_dec;
                if (cap > CAP_W'(1) && {1'b0, count_dec} <= (cap >> 1)) begin
                  cap_next = cap >> 1;
                end
                rd_ptr_next  = cmd.index + ADDR_W'(1);
                rd_left_next = count_dec - {1'b0, cmd.index};
                op_ins_next  = 1'b0;
                state_next   = ST_SHIFT;
              end
            end
            KIND_EDIT: begin
              if (!idx_good) begin
                op_err_next = ERR_INDEX;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cmd.index;
                mem_wdata = cmd.value[DATA_WIDTH-1:0];
              end
            end
            KIND_READ: begin
              if (!idx_good) begin
                op_err_next = ERR_INDEX;
                rsel_next   = RD_ONES;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = cmd.index;
                rsel_next = RD_MEM;
              end
            end
            KIND_CLEAR: begin
              count_next = '0;
              cap_next   = start_cap;
            end
            default: ;
          endcase
        end
      end

      // Move entries one place: read one, write the previous read back
      ST_SHIFT: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr;
          mem_wdata = rd_data;
        end
        if (rd_left != '0) begin
          mem_re         = 1'b1;
          mem_raddr      = rd_ptr;
          pend_next      = 1'b1;
          pend_addr_next = op_ins ? rd_ptr + ADDR_W'(1) : rd_ptr - ADDR_W'(1);
          rd_ptr_next    = op_ins ? rd_ptr - ADDR_W'(1) : rd_ptr + ADDR_W'(1);
          rd_left_next   = rd_left - CNT_W'(1);
        end else begin
          state_next = op_ins ? ST_PUT : ST_DONE;
        end
      end

      // Insert: store the new word in the freed slot
      ST_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = put_addr;
        mem_wdata  = put_word;
        state_next = ST_DONE;
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Result word selection
  always_comb begin
    case (rsel)
      RD_MEM:  read_mux = WORD_W'($signed(rd_data));
      RD_ONES: read_mux = '1;
      default: read_mux = '0;
    endcase
  end

  // RAM: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cap       <= CAP_W'(1);
      init_cap  <= ICAP_W'(1);
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      cap   <= cap_next;
      pend  <= pend_next;
      if (cfg.valid) init_cap <= cfg.data;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    rd_ptr    <= rd_ptr_next;
    rd_left   <= rd_left_next;
    op_ins    <= op_ins_next;
    op_err    <= op_err_next;
    rsel      <= rsel_next;
    put_addr  <= put_addr_next;
    put_word  <= put_word_next;
    if (out_load) begin
      out_read  <= read_mux;
      out_err   <= op_err;
      out_count <= count;
      out_cap   <= cap;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_read;
  assign rsp.error      = out_err;
  assign rsp.count      = out_count;
  assign rsp.capacity   = out_cap;

`ifndef NO_ASSERTIONS
  // Count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above store depth");

  // Capacity is never zero and never below the count
  a_cap_cover: assert property (@(posedge clk) disable iff (rst)
    cap != '0 && cap >= {1'b0, count})
    else $error("capacity below entry count");

  // No shift write is left behind when the sequencer goes idle
  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend)
    else $error("pending shift write while idle");

  // RAM writes while idle only come from an accepted command
  a_idle_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == ST_IDLE) |-> accept)
    else $error("RAM write while idle without a command");

  // A result is only loaded from the done state
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result loaded outside done state");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for indexed_list_insert_delete_core
// Drives list operations through the command channel and compares every
// response field with a shadow list kept in the bench. A short directed
// table comes first, then random operations on small lists and a store-full
// fill, under several initial-capacity settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb;
  import ilid_pkg::*;

  // Spare opcodes: the core must treat them as no-ops
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
  // Random lists stay around this size so shifts stay cheap
  localparam int unsigned LIST_SOFT_MAX = 40;

  typedef struct {
    logic signed [WORD_W-1:0] read_value;
    err_t                     error;
    logic [CNT_W-1:0]         count;
    logic [CAP_W-1:0]         capacity;
  } list_result_t;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [INDEX_W-1:0]       index;
    logic signed [WORD_W-1:0] value;
    bit                       fixed_want;
    list_result_t             want;
  } list_op_t;

  logic clk;
  logic rst;

  ilid_cfg_if cfg_if ();
  ilid_cmd_if cmd_if ();
  ilid_rsp_if rsp_if ();

  indexed_list_insert_delete_core u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  // Shadow copy of the list state
  logic signed [WORD_W-1:0] shadow_store [DEPTH];
  int unsigned              shadow_count;
  int unsigned              shadow_cap;
  int unsigned              shadow_icap;

  list_result_t pending_results[$];
  list_op_t     directed_ops[$];

  int mismatch_count  = 0;
  int tx_idle_pct     = 0;
  int rx_idle_pct     = 0;
  int rsp_hold_cycles = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Apply one operation to the shadow list and return its response
  function automatic list_result_t apply_list_op(input logic [KIND_W-1:0] k,
                                                 input logic [INDEX_W-1:0] idx,
                                                 input logic signed [WORD_W-1:0] v);
    list_result_t r;
    bit           in_range;
    int unsigned  i;
    r.read_value = '0;
    r.error      = ERR_OK;
    in_range     = idx < shadow_count;
    case (k)
      KIND_APPEND: begin
        if (shadow_count >= DEPTH) begin
          r.error = ERR_FULL;
        end else begin
          if (shadow_count == shadow_cap) shadow_cap = shadow_cap * 2;
          shadow_store[shadow_count] = v;
          shadow_count++;
        end
      end
      KIND_INSERT: begin
        if (!in_range) begin
          r.error = ERR_INDEX;
        end else if (shadow_count >= DEPTH) begin
          r.error = ERR_FULL;
        end else begin
          if (shadow_count == shadow_cap) shadow_cap = shadow_cap * 2;
          for (i = shadow_count; i > idx; i--) shadow_store[i] = shadow_store[i-1];
          shadow_store[idx] = v;
          shadow_count++;
        end
      end
      KIND_DELETE: begin
        if (!in_range) begin
          r.error = ERR_INDEX;
        end else begin
          for (i = idx; i + 1 < shadow_count; i++) shadow_store[i] = shadow_store[i+1];
          shadow_count--;
          if (shadow_cap > 1 && shadow_count <= shadow_cap / 2) shadow_cap = shadow_cap / 2;
        end
      end
      KIND_EDIT: begin
        if (!in_range) r.error = ERR_INDEX;
        else shadow_store[idx] = v;
      end
      KIND_READ: begin
        if (!in_range) begin
          r.error      = ERR_INDEX;
          r.read_value = '1;
        end else begin
          r.read_value = shadow_store[idx];
        end
      end
      KIND_CLEAR: begin
        shadow_count = 0;
        // register value clamped into 1..DEPTH
        if (shadow_icap == 0) shadow_cap = 1;
        else if (shadow_icap > DEPTH) shadow_cap = DEPTH;
        else shadow_cap = shadow_icap;
      end
      default: ;
    endcase
    r.count    = CNT_W'(shadow_count);
    r.capacity = CAP_W'(shadow_cap);
    return r;
  endfunction

  function automatic list_op_t make_op(input logic [KIND_W-1:0] k,
                                       input logic [INDEX_W-1:0] idx,
                                       input logic signed [WORD_W-1:0] v,
                                       input bit fixed = 1'b0,
                                       input logic signed [WORD_W-1:0] rd = '0,
                                       input err_t e = ERR_OK,
                                       input int cnt = 0,
                                       input int cap = 0);
    list_op_t op;
    op.kind                = k;
    op.index               = idx;
    op.value               = v;
    op.fixed_want          = fixed;
    op.want.read_value     = rd;
    op.want.error          = e;
    op.want.count          = CNT_W'(cnt);
    op.want.capacity       = CAP_W'(cap);
    return op;
  endfunction

  // Random operation, mostly on valid indices of a small list
  function automatic list_op_t pick_list_op();
    list_op_t    op;
    int unsigned sel;
    int unsigned lo;
    sel           = $urandom_range(99);
    op.fixed_want = 1'b0;
    op.want       = apply_list_op(KIND_SPARE6, '0, '0);
    if (shadow_count > 0) op.index = INDEX_W'($urandom_range(shadow_count - 1));
    else op.index = INDEX_W'($urandom_range(DEPTH - 1));
    case ($urandom_range(9))
      0:       op.value = 32'sh7FFF_FFFF;
      1:       op.value = 32'sh8000_0000;
      2:       op.value = '1;
      3:       op.value = '0;
      default: op.value = $urandom;
    endcase
    if (sel < 28) op.kind = KIND_APPEND;
    else if (sel < 43) op.kind = KIND_INSERT;
    else if (sel < 58) op.kind = KIND_DELETE;
    else if (sel < 68) op.kind = KIND_EDIT;
    else if (sel < 88) op.kind = KIND_READ;
    else if (sel < 90) op.kind = KIND_CLEAR;
    else if (sel < 93) op.kind = $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
    else begin
      // out-of-range index on an indexed operation
      op.kind  = KIND_W'($urandom_range(KIND_READ, KIND_INSERT));
      lo       = (shadow_count < DEPTH) ? shadow_count : DEPTH - 1;
      op.index = INDEX_W'($urandom_range(DEPTH - 1, lo));
    end
    if (shadow_count >= LIST_SOFT_MAX && (op.kind == KIND_APPEND || op.kind == KIND_INSERT))
      op.kind = KIND_DELETE;
    return op;
  endfunction

  // One command transfer; valid is left high after the transfer
  task automatic send_item(input list_op_t op);
    list_result_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.kind  <= op.kind;
    cmd_if.index <= op.index;
    cmd_if.value <= op.value;
    do @(posedge clk); while (!cmd_if.ready);
    r = apply_list_op(op.kind, op.index, op.value);
    if (op.fixed_want) r = op.want;
    pending_results.push_back(r);
  endtask

  task automatic wait_all_results();
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the initial capacity while idle, then clear to load it
  task automatic load_init_cap(input logic [ICAP_W-1:0] v);
    wait_all_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    shadow_icap = v;
    send_item(make_op(KIND_CLEAR, '0, '0));
  endtask

  task automatic run_random(input int n);
    repeat (n) send_item(pick_list_op());
  endtask

  task automatic check_result();
    list_result_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result rv=%0d err=%0d count=%0d cap=%0d", $time,
               rsp_if.read_value, rsp_if.error, rsp_if.count, rsp_if.capacity);
    end else begin
      want = pending_results.pop_front();
      if (rsp_if.read_value !== want.read_value) begin
        mismatch_count++;
        $display("%0t: read_value expected %0d actual %0d", $time,
                 want.read_value, rsp_if.read_value);
      end
      if (rsp_if.error !== want.error) begin
        mismatch_count++;
        $display("%0t: error expected %0d actual %0d", $time, want.error, rsp_if.error);
      end
      if (rsp_if.count !== want.count) begin
        mismatch_count++;
        $display("%0t: count expected %0d actual %0d", $time, want.count, rsp_if.count);
      end
      if (rsp_if.capacity !== want.capacity) begin
        mismatch_count++;
        $display("%0t: capacity expected %0d actual %0d", $time,
                 want.capacity, rsp_if.capacity);
      end
    end
  endtask

  // Response side: check transfers, random ready, long hold-off on request
  initial begin : rsp_side
    int hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) check_result();
      if (rsp_hold_cycles > 0) begin
        hold_left       = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Stimulus
  initial begin : stim
    rst          <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.kind  <= KIND_APPEND;
    cmd_if.index <= '0;
    cmd_if.value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    shadow_count = 0;
    shadow_cap   = 1;
    shadow_icap  = 1;
    tx_idle_pct  = 22;
    rx_idle_pct  = 76;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table, reset capacity 1
    directed_ops.push_back(make_op(KIND_READ,   0, 0, 1, -1, ERR_INDEX, 0, 1));
    directed_ops.push_back(make_op(KIND_DELETE, 0, 0, 1, 0, ERR_INDEX, 0, 1));
    directed_ops.push_back(make_op(KIND_INSERT, 0, 5, 1, 0, ERR_INDEX, 0, 1));
    directed_ops.push_back(make_op(KIND_EDIT,   0, 5, 1, 0, ERR_INDEX, 0, 1));
    directed_ops.push_back(make_op(KIND_APPEND, 0, 32'sh7FFF_FFFF, 1, 0, ERR_OK, 1, 1));
    directed_ops.push_back(make_op(KIND_APPEND, 0, 32'sh8000_0000, 1, 0, ERR_OK, 2, 2));
    directed_ops.push_back(make_op(KIND_READ,   0, 0, 1, 32'sh7FFF_FFFF, ERR_OK, 2, 2));
    directed_ops.push_back(make_op(KIND_READ,   1, 0, 1, 32'sh8000_0000, ERR_OK, 2, 2));
    directed_ops.push_back(make_op(KIND_INSERT, 1, -1, 1, 0, ERR_OK, 3, 4));
    // insert at index == count is out of range
    directed_ops.push_back(make_op(KIND_INSERT, 3, 7, 1, 0, ERR_INDEX, 3, 4));
    directed_ops.push_back(make_op(KIND_READ, 1023, -1, 1, -1, ERR_INDEX, 3, 4));
    directed_ops.push_back(make_op(KIND_EDIT,   0, 0, 1, 0, ERR_OK, 3, 4));
    directed_ops.push_back(make_op(KIND_READ,   2, 0));
    directed_ops.push_back(make_op(KIND_INSERT, 0, 32'sh5A5A_5A5A));
    directed_ops.push_back(make_op(KIND_APPEND, 0, 32'shA5A5_A5A5));
    directed_ops.push_back(make_op(KIND_DELETE, 0, 0));
    directed_ops.push_back(make_op(KIND_DELETE, 3, 0));
    directed_ops.push_back(make_op(KIND_READ,   0, 0));
    directed_ops.push_back(make_op(KIND_READ,   2, 0));
    directed_ops.push_back(make_op(KIND_SPARE6, 1023, -1));
    directed_ops.push_back(make_op(KIND_SPARE7, 0, 0));
    directed_ops.push_back(make_op(KIND_CLEAR,  0, 0, 1, 0, ERR_OK, 0, 1));
    directed_ops.push_back(make_op(KIND_APPEND, 0, 32'sh1234_5678, 1, 0, ERR_OK, 1, 1));
    // capacity 1 never halves
    directed_ops.push_back(make_op(KIND_DELETE, 0, 0, 1, 0, ERR_OK, 0, 1));
    directed_ops.push_back(make_op(KIND_EDIT, 1023, -1, 1, 0, ERR_INDEX, 0, 1));
    foreach (directed_ops[n]) send_item(directed_ops[n]);

    // Zero register reads as capacity 1
    load_init_cap(11'd0);
    run_random(100);

    // Oversized register clamps to DEPTH; fill the store to the top
    load_init_cap(11'd2047);
    while (shadow_count < DEPTH) send_item(make_op(KIND_APPEND, $urandom, $urandom));
    send_item(make_op(KIND_APPEND, 0, 1, 1, 0, ERR_FULL, 1024, 1024));
    send_item(make_op(KIND_INSERT, 0, 1, 1, 0, ERR_FULL, 1024, 1024));
    send_item(make_op(KIND_INSERT, 1023, 1, 1, 0, ERR_FULL, 1024, 1024));
    send_item(make_op(KIND_EDIT, 1023, -1, 1, 0, ERR_OK, 1024, 1024));
    send_item(make_op(KIND_READ, 1023, 0, 1, -1, ERR_OK, 1024, 1024));
    send_item(make_op(KIND_DELETE, 1023, 0, 1, 0, ERR_OK, 1023, 1024));
    send_item(make_op(KIND_APPEND, 0, 32'sh7FFF_FFFF, 1, 0, ERR_OK, 1024, 1024));
    send_item(make_op(KIND_READ, 1023, 0, 1, 32'sh7FFF_FFFF, ERR_OK, 1024, 1024));
    send_item(make_op(KIND_DELETE, 0, 0, 1, 0, ERR_OK, 1023, 1024));
    send_item(make_op(KIND_READ, 0, 0));
    send_item(make_op(KIND_INSERT, 0, 32'sh8000_0000, 1, 0, ERR_OK, 1024, 1024));
    send_item(make_op(KIND_READ, 0, 0, 1, 32'sh8000_0000, ERR_OK, 1024, 1024));

    load_init_cap(11'd3);
    run_random(90);

    // Sender mostly idle, receiver mostly ready
    tx_idle_pct = 76;
    rx_idle_pct = 22;
    load_init_cap(11'd1024);
    run_random(100);
    load_init_cap(ICAP_W'($urandom_range(DEPTH, 1)));
    run_random(100);

    // No idling; one long response hold-off while commands keep coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_init_cap(11'd7);
    run_random(40);
    rsp_hold_cycles = 300;
    run_random(60);
    load_init_cap(11'd1);
    run_random(90);

    wait_all_results();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

// File: sim.f
sv/ilid_pkg.sv
sv/ilid_if.sv
sv/indexed_list_insert_delete_core.sv
tb/tb.sv
